### sv/bhx_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the alphabet lookup for the BinHex 4.0 stream decoder.
// Depends on nothing; used by binhex_stream_decoder and bhx_checker.
package bhx_pkg;

  localparam logic [7:0] ESCAPE_BYTE = 8'h90;
  localparam logic [7:0] END_CHAR    = 8'h3A;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_END     = 2'd1,
    ST_BAD_RUN = 2'd2
  } status_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] code;
  } sym_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] count;
    status_t    status;
  } res_t;

  // The 64 symbols fall into nine runs of consecutive character codes, so each
  // run maps to its code by one constant offset.
  function automatic sym_t symbol_lookup(input logic [7:0] c);
    sym_t s;
    logic [7:0] d;
    s.hit = 1'b1;
    d = 8'h00;
    if (c >= 8'h21 && c <= 8'h2D) begin
      d = c - 8'h21;
    end else if (c >= 8'h30 && c <= 8'h36) begin
      d = c - 8'h23;
    end else if (c >= 8'h38 && c <= 8'h39) begin
      d = c - 8'h24;
    end else if (c >= 8'h40 && c <= 8'h4E) begin
      d = c - 8'h2A;
    end else if (c >= 8'h50 && c <= 8'h56) begin
      d = c - 8'h2B;
    end else if (c >= 8'h58 && c <= 8'h5B) begin
      d = c - 8'h2C;
    end else if (c >= 8'h60 && c <= 8'h66) begin
      d = c - 8'h30;
    end else if (c >= 8'h68 && c <= 8'h6D) begin
      d = c - 8'h31;
    end else if (c >= 8'h70 && c <= 8'h72) begin
      d = c - 8'h33;
    end else begin
      s.hit = 1'b0;
    end
    s.code = d[5:0];
    return s;
  endfunction

endpackage

### sv/binhex_stream_decoder.sv
`timescale 1ns / 1ps
// Top level of the BinHex 4.0 stream decoder: symbol map, 6-to-8 bit packing,
// 0x90 run expansion and a two-entry output stage. Depends on bhx_pkg.
//
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_valid / in_stall | in_char_code[7:0], in_restart
//  out_    | output    | out_valid/out_stall | out_out_byte[7:0], out_repeat_count[7:0],
//          |           |                     | out_status[1:0]
//
// One character is taken every cycle while in_stall is low; its result, if any, is
// registered in the output register. A skid register behind it lets one more character
// in while a result waits under out_stall; in_stall rises only when both are full.
// rst_n is synchronous and clears all decoder state and both output valid flags.
module binhex_stream_decoder
  import bhx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [7:0] out_repeat_count,
  output logic [1:0] out_status
);

  logic [1:0] phase_r, phase_nxt;
  logic [5:0] held_r, held_nxt;
  logic [7:0] last_r, last_nxt;
  logic       await_r, await_nxt;
  logic       stopped_r, stopped_nxt;

  logic       out_valid_r, skid_valid_r;
  res_t       out_res_r, skid_res_r;

  logic       in_xfer, out_xfer;
  logic       res_vld;
  res_t       res;
  sym_t       sym;
  logic [7:0] pack_byte;

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  assign out_xfer = out_valid_r && !out_stall;
  assign sym      = symbol_lookup(in_char_code);

  always_comb begin
    case (phase_r)
      2'd1:    pack_byte = {held_r, sym.code[5:4]};
      2'd2:    pack_byte = {held_r[3:0], sym.code[5:2]};
      2'd3:    pack_byte = {held_r[1:0], sym.code};
      default: pack_byte = 8'h00;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    last_nxt    = last_r;
    await_nxt   = await_r;
    stopped_nxt = stopped_r;
    res_vld     = 1'b0;
    res.data    = 8'h00;
    res.count   = 8'h00;
    res.status  = ST_DATA;
    if (in_xfer) begin
      if (in_restart) begin
        phase_nxt   = 2'd0;
        held_nxt    = 6'd0;
        last_nxt    = 8'h00;
        await_nxt   = 1'b0;
        stopped_nxt = 1'b0;
      end else if (stopped_r) begin
        // Everything is ignored until the next restart.
      end else if (in_char_code == END_CHAR) begin
        stopped_nxt = 1'b1;
        res_vld     = 1'b1;
        res.status  = ST_END;
      end else if (sym.hit) begin
        held_nxt  = sym.code;
        phase_nxt = phase_r + 2'd1;
        if (phase_r != 2'd0) begin
          if (await_r) begin
            await_nxt = 1'b0;
            res_vld   = 1'b1;
            if (pack_byte == 8'h00) begin
              last_nxt  = ESCAPE_BYTE;
              res.data  = ESCAPE_BYTE;
              res.count = 8'd1;
            end else if (pack_byte == 8'h01) begin
              stopped_nxt = 1'b1;
              res.status  = ST_BAD_RUN;
            end else begin
              res.data  = last_r;
              res.count = pack_byte - 8'd1;
            end
          end else if (pack_byte == ESCAPE_BYTE) begin
            await_nxt = 1'b1;
          end else begin
            last_nxt  = pack_byte;
            res_vld   = 1'b1;
            res.data  = pack_byte;
            res.count = 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 2'd0;
      held_r       <= 6'd0;
      last_r       <= 8'h00;
      await_r      <= 1'b0;
      stopped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      last_r    <= last_nxt;
      await_r   <= await_nxt;
      stopped_r <= stopped_nxt;
      if (skid_valid_r) begin
        // No input transfer can happen here, so only the drain matters.
        if (out_xfer) begin
          out_res_r    <= skid_res_r;
          skid_valid_r <= 1'b0;
        end
      end else if (!out_valid_r || out_xfer) begin
        out_valid_r <= res_vld;
        if (res_vld) begin
          out_res_r <= res;
        end
      end else if (res_vld) begin
        skid_res_r   <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_out_byte     = out_res_r.data;
  assign out_repeat_count = out_res_r.count;
  assign out_status       = out_res_r.status;

endmodule

### sv/bhx_checker.sv
`timescale 1ns / 1ps
// Port-level checks for binhex_stream_decoder, attached by the bind below.
// Depends on bhx_pkg for the status codes.
module bhx_checker
  import bhx_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_out_byte,
  input logic [7:0] out_repeat_count,
  input logic [1:0] out_status
);

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_out_byte) && $stable(out_repeat_count)
                               && $stable(out_status))
    else $error("stalled result changed");

  // End and bad-run results carry no byte and no count.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_END || out_status == ST_BAD_RUN)
      |-> out_out_byte == 8'h00 && out_repeat_count == 8'h00)
    else $error("status result with nonzero payload");

  // A data result always stands for at least one byte, at most 254.
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DATA
      |-> out_repeat_count != 8'h00 && out_repeat_count != 8'hFF)
    else $error("data result with bad repeat count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

endmodule

bind binhex_stream_decoder bhx_checker u_bhx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_out_byte     (out_out_byte),
  .out_repeat_count (out_repeat_count),
  .out_status       (out_status)
);
